// ----- src/line_position_estimator_macros.svh -----
// assertion macros used by the line position estimator checker
`ifndef LINE_POSITION_ESTIMATOR_MACROS_SVH
`define LINE_POSITION_ESTIMATOR_MACROS_SVH

// implication checked outside reset
`define LPE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define LPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define LPE_ASSERT_RESET(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/lpe_pkg.sv -----
// types and constants of the line position estimator
`default_nettype none
package lpe_pkg;
   localparam int NUM_SENSORS = 8;
   localparam int READING_W   = 16;
   localparam int DIV_W       = 17;
   localparam int WEIGHT_W    = 24;
   localparam int SQ_W        = 2 * WEIGHT_W;
   localparam int T_W         = SQ_W + 3;
   localparam int S_W         = SQ_W + 6;
   localparam int LINE_W      = 25;
   localparam int POS_W       = 16;
   localparam int Q_W         = 17;

   localparam logic [POS_W-1:0] Q_MAX    = 16'hFFFF;
   localparam logic [POS_W-1:0] POS_BIAS = 16'h8000;

   typedef logic [NUM_SENSORS-1:0][READING_W-1:0] reading_arr_type;

   typedef struct packed {
      logic [S_W-1:0]    s;
      logic [T_W-1:0]    t;
      logic [LINE_W-1:0] lineness;
   } moments_type;

   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic [LINE_W-1:0]       lineness;
      logic                    flat_frame;
   } result_type;
endpackage
`default_nettype wire

// ----- src/lpe_ifs.sv -----
// request and response channel interfaces
`default_nettype none
interface lpe_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] reading_0;
   logic [15:0] reading_1;
   logic [15:0] reading_2;
   logic [15:0] reading_3;
   logic [15:0] reading_4;
   logic [15:0] reading_5;
   logic [15:0] reading_6;
   logic [15:0] reading_7;
   modport source (output valid, reading_0, reading_1, reading_2, reading_3,
                   reading_4, reading_5, reading_6, reading_7, input ready);
   modport sink (input valid, reading_0, reading_1, reading_2, reading_3,
                 reading_4, reading_5, reading_6, reading_7, output ready);
endinterface

interface lpe_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] position;
   logic [24:0]        lineness;
   logic               flat_frame;
   modport source (output valid, position, lineness, flat_frame, input ready);
   modport sink (input valid, position, lineness, flat_frame, output ready);
endinterface
`default_nettype wire

// ----- src/lpe_recip.sv -----
// pipelined restoring divider forming 2^frac / (1 + reading) for all sensors
`default_nettype none
module lpe_recip import lpe_pkg::*; #(
   parameter int FRAC_BITS = 24
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  en,
   input  wire logic                                  in_valid,
   input  wire reading_arr_type                       readings,
   output logic                                       out_valid,
   output logic [NUM_SENSORS-1:0][FRAC_BITS:0]        levels
);
   localparam int NST = FRAC_BITS + 1;

   logic                                   vld_ff [NST];
   logic [NUM_SENSORS-1:0][DIV_W-1:0]      div_ff [NST];
   logic [NUM_SENSORS-1:0][DIV_W-1:0]      rem_ff [NST];
   logic [NUM_SENSORS-1:0][FRAC_BITS:0]    quo_ff [NST];

   for (genvar s = 0; s < NST; s++) begin : g_stage
      logic                                vld_prev;
      logic [NUM_SENSORS-1:0][DIV_W-1:0]   div_prev;
      logic [NUM_SENSORS-1:0][DIV_W-1:0]   rem_prev;
      logic [NUM_SENSORS-1:0][FRAC_BITS:0] quo_prev;
      logic                                num_bit;
      logic [NUM_SENSORS-1:0][DIV_W-1:0]   rem_in;
      logic [NUM_SENSORS-1:0][FRAC_BITS:0] quo_in;

      if (s == 0) begin : g_first
         always_comb begin
            for (int k = 0; k < NUM_SENSORS; k++) begin
               div_prev[k] = DIV_W'(readings[k]) + DIV_W'(1);
            end
         end
         assign vld_prev = in_valid;
         assign rem_prev = '0;
         assign quo_prev = '0;
         // the only set dividend bit is the top one
         assign num_bit  = 1'b1;
      end else begin : g_next
         assign vld_prev = vld_ff[s-1];
         assign div_prev = div_ff[s-1];
         assign rem_prev = rem_ff[s-1];
         assign quo_prev = quo_ff[s-1];
         assign num_bit  = 1'b0;
      end

      always_comb begin
         logic [DIV_W:0] rem_sh;
         logic           ge;
         for (int k = 0; k < NUM_SENSORS; k++) begin
            rem_sh    = {rem_prev[k], num_bit};
            ge        = rem_sh >= {1'b0, div_prev[k]};
            rem_in[k] = ge ? DIV_W'(rem_sh - {1'b0, div_prev[k]}) : DIV_W'(rem_sh);
            quo_in[k] = {quo_prev[k][FRAC_BITS-1:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[s] <= div_prev;
            rem_ff[s] <= rem_in;
            quo_ff[s] <= quo_in;
         end
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign levels    = quo_ff[NST-1];
endmodule
`default_nettype wire

// ----- src/lpe_moments.sv -----
// minimum removal, squared weights and weighted sums over the sensors
`default_nettype none
module lpe_moments import lpe_pkg::*; #(
   parameter int FRAC_BITS = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic                              in_valid,
   input  wire logic [NUM_SENSORS-1:0][FRAC_BITS:0] levels,
   output logic                                   out_valid,
   output moments_type                            moments
);
   localparam int LVW = FRAC_BITS + 1;
   localparam int SH  = (FRAC_BITS > WEIGHT_W) ? FRAC_BITS - WEIGHT_W : 0;
   localparam int NV  = 8;

   logic [NV-1:0] vld_ff;

   logic [NUM_SENSORS-1:0][LVW-1:0] lv1_ff, lv2_ff, lv3_ff;
   logic [3:0][LVW-1:0]             mn1_ff, mx1_ff;
   logic [1:0][LVW-1:0]             mn2_ff, mx2_ff;
   logic [LVW-1:0]                  lo3_ff, hi3_ff;
   logic [NUM_SENSORS-1:0][WEIGHT_W-1:0] w4_ff;
   logic [LVW-1:0]                  pk4_ff, pk5_ff, pk6_ff, pk7_ff;
   logic [NUM_SENSORS-1:0][SQ_W-1:0] sq5_ff;
   logic [3:0][T_W-1:0]             t6_ff, t6_in;
   logic [3:0][S_W-1:0]             s6_ff, s6_in;
   logic [1:0][T_W-1:0]             t7_ff;
   logic [1:0][S_W-1:0]             s7_ff;
   moments_type                     mom_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         t6_in[k] = T_W'(sq5_ff[2*k]) + T_W'(sq5_ff[2*k+1]);
         s6_in[k] = S_W'(sq5_ff[2*k]) * S_W'(2*k) + S_W'(sq5_ff[2*k+1]) * S_W'(2*k+1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NV-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // min and max trees
         lv1_ff <= levels;
         for (int k = 0; k < 4; k++) begin
            mn1_ff[k] <= (levels[2*k] < levels[2*k+1]) ? levels[2*k] : levels[2*k+1];
            mx1_ff[k] <= (levels[2*k] > levels[2*k+1]) ? levels[2*k] : levels[2*k+1];
         end
         lv2_ff <= lv1_ff;
         for (int k = 0; k < 2; k++) begin
            mn2_ff[k] <= (mn1_ff[2*k] < mn1_ff[2*k+1]) ? mn1_ff[2*k] : mn1_ff[2*k+1];
            mx2_ff[k] <= (mx1_ff[2*k] > mx1_ff[2*k+1]) ? mx1_ff[2*k] : mx1_ff[2*k+1];
         end
         lv3_ff <= lv2_ff;
         lo3_ff <= (mn2_ff[0] < mn2_ff[1]) ? mn2_ff[0] : mn2_ff[1];
         hi3_ff <= (mx2_ff[0] > mx2_ff[1]) ? mx2_ff[0] : mx2_ff[1];
         // weights
         for (int k = 0; k < NUM_SENSORS; k++) begin
            w4_ff[k] <= WEIGHT_W'((lv3_ff[k] - lo3_ff) >> SH);
         end
         pk4_ff <= hi3_ff - lo3_ff;
         for (int k = 0; k < NUM_SENSORS; k++) begin
            sq5_ff[k] <= SQ_W'(w4_ff[k]) * SQ_W'(w4_ff[k]);
         end
         pk5_ff <= pk4_ff;
         // sum trees
         t6_ff  <= t6_in;
         s6_ff  <= s6_in;
         pk6_ff <= pk5_ff;
         t7_ff[0] <= t6_ff[0] + t6_ff[1];
         t7_ff[1] <= t6_ff[2] + t6_ff[3];
         s7_ff[0] <= s6_ff[0] + s6_ff[1];
         s7_ff[1] <= s6_ff[2] + s6_ff[3];
         pk7_ff   <= pk6_ff;
         mom_ff.t        <= t7_ff[0] + t7_ff[1];
         mom_ff.s        <= s7_ff[0] + s7_ff[1];
         mom_ff.lineness <= LINE_W'(pk7_ff);
      end
   end

   assign out_valid = vld_ff[NV-1];
   assign moments   = mom_ff;
endmodule
`default_nettype wire

// ----- src/lpe_ratio.sv -----
// pipelined long division of the centroid and the output register
`default_nettype none
module lpe_ratio import lpe_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire moments_type moments,
   output logic             out_valid,
   output result_type       result
);
   logic              v0_ff;
   logic [S_W-1:0]    den0_ff, s0_ff;
   logic              flat0_ff;
   logic [LINE_W-1:0] line0_ff;

   logic              vld_ff  [Q_W];
   logic [S_W-1:0]    den_ff  [Q_W];
   logic [S_W-1:0]    rem_ff  [Q_W];
   logic [Q_W-1:0]    quo_ff  [Q_W];
   logic              flat_ff [Q_W];
   logic [LINE_W-1:0] line_ff [Q_W];

   logic              vout_ff;
   result_type        res_ff, res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den0_ff  <= (S_W'(moments.t) << 3) - S_W'(moments.t);
         s0_ff    <= moments.s;
         flat0_ff <= moments.t == '0;
         line0_ff <= moments.lineness;
      end
   end

   for (genvar j = 0; j < Q_W; j++) begin : g_div
      logic              vld_prev;
      logic [S_W-1:0]    den_prev;
      logic [S_W:0]      cand;
      logic [Q_W-1:0]    quo_prev;
      logic              flat_prev;
      logic [LINE_W-1:0] line_prev;
      logic              ge;

      if (j == 0) begin : g_first
         // integer part of s / den, zero or one
         assign vld_prev  = v0_ff;
         assign den_prev  = den0_ff;
         assign cand      = {1'b0, s0_ff};
         assign quo_prev  = '0;
         assign flat_prev = flat0_ff;
         assign line_prev = line0_ff;
      end else begin : g_next
         assign vld_prev  = vld_ff[j-1];
         assign den_prev  = den_ff[j-1];
         assign cand      = {rem_ff[j-1], 1'b0};
         assign quo_prev  = quo_ff[j-1];
         assign flat_prev = flat_ff[j-1];
         assign line_prev = line_ff[j-1];
      end

      assign ge = cand >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[j]  <= den_prev;
            rem_ff[j]  <= ge ? S_W'(cand - {1'b0, den_prev}) : S_W'(cand);
            quo_ff[j]  <= {quo_prev[Q_W-2:0], ge};
            flat_ff[j] <= flat_prev;
            line_ff[j] <= line_prev;
         end
      end
   end

   always_comb begin
      logic [POS_W-1:0] qsat;
      qsat = quo_ff[Q_W-1][Q_W-1] ? Q_MAX : quo_ff[Q_W-1][POS_W-1:0];
      res_in.lineness   = line_ff[Q_W-1];
      res_in.flat_frame = flat_ff[Q_W-1];
      res_in.position   = flat_ff[Q_W-1] ? '0 : $signed(qsat ^ POS_BIAS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else if (en) begin
         vout_ff <= vld_ff[Q_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = vout_ff;
   assign result    = res_ff;
endmodule
`default_nettype wire

// ----- src/line_position_estimator.sv -----
// top level of the line position estimator
`default_nettype none
// Accepts one frame of eight reflectance readings per clock and returns one
// transaction per frame, in order: position in signed Q1.15 (-1 leftmost,
// saturating at +1 rightmost), lineness (largest level above the frame
// minimum) and a flat flag when all levels are equal. The pipeline holds
// FRAC_BITS + 1 stages of the per-sensor reciprocal divider, 8 stages of
// min/max, squaring and sum trees, and 19 stages of centroid long
// division and output register. The whole pipeline advances together, so
// a held response stalls the request side in the same cycle; otherwise a
// frame enters every cycle.
module line_position_estimator import lpe_pkg::*; #(
   parameter int FRAC_BITS = 24
) (
   input wire logic clock,
   input wire logic reset,
   lpe_req_if.sink  req_bus,
   lpe_rsp_if.source rsp_bus
);
   logic                              en;
   reading_arr_type                   readings;
   logic                              lvl_valid, mom_valid, res_valid;
   logic [NUM_SENSORS-1:0][FRAC_BITS:0] levels;
   moments_type                       moments;
   result_type                        result;

   assign en = !res_valid || rsp_bus.ready;

   assign readings[0] = req_bus.reading_0;
   assign readings[1] = req_bus.reading_1;
   assign readings[2] = req_bus.reading_2;
   assign readings[3] = req_bus.reading_3;
   assign readings[4] = req_bus.reading_4;
   assign readings[5] = req_bus.reading_5;
   assign readings[6] = req_bus.reading_6;
   assign readings[7] = req_bus.reading_7;

   lpe_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_bus.valid),
      .readings  (readings),
      .out_valid (lvl_valid),
      .levels    (levels)
   );

   lpe_moments #(.FRAC_BITS(FRAC_BITS)) u_moments (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (lvl_valid),
      .levels    (levels),
      .out_valid (mom_valid),
      .moments   (moments)
   );

   lpe_ratio u_ratio (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mom_valid),
      .moments   (moments),
      .out_valid (res_valid),
      .result    (result)
   );

   assign req_bus.ready      = en;
   assign rsp_bus.valid      = res_valid;
   assign rsp_bus.position   = result.position;
   assign rsp_bus.lineness   = result.lineness;
   assign rsp_bus.flat_frame = result.flat_frame;
endmodule
`default_nettype wire

// ----- src/lpe_checker.sv -----
// port-level checks for the line position estimator
`default_nettype none
`include "line_position_estimator_macros.svh"
module lpe_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [15:0] rsp_position,
   input wire logic [24:0]        rsp_lineness,
   input wire logic               rsp_flat_frame
);
   `LPE_ASSERT_RESET(a_reset_clears, clock, reset, !rsp_valid, "response valid after reset")
   `LPE_ASSERT_IMPL(a_ready_follows, clock, reset, 1'b1, req_ready == (!rsp_valid || rsp_ready), "request ready does not track response stall")
   `LPE_ASSERT_IMPL(a_flat_zero, clock, reset, rsp_valid && rsp_flat_frame, rsp_position == 16'sd0, "flat frame with nonzero position")
   `LPE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_position) && $stable(rsp_lineness) && $stable(rsp_flat_frame), "stalled response changed")
endmodule

bind line_position_estimator lpe_checker u_lpe_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_position   (rsp_bus.position),
   .rsp_lineness   (rsp_bus.lineness),
   .rsp_flat_frame (rsp_bus.flat_frame)
);
`default_nettype wire

// ----- sim/testbench.sv -----
// self-checking testbench of the line position estimator
module testbench;
   import lpe_pkg::*;

   localparam int FRAC = 24;
   localparam int LATENCY = FRAC + 28;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lpe_req_if req_bus();
   lpe_rsp_if rsp_bus();

   line_position_estimator #(.FRAC_BITS(FRAC)) u_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   result_type expected_q[$];
   int mismatch_count = 0;
   int frames_sent = 0;
   int results_seen = 0;
   int flat_seen = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit recv_hold = 1'b0;
   int quiet_cycles = 0;

   // centroid of squared levels above the frame minimum
   function automatic result_type estimate_position(input reading_arr_type rd);
      logic [63:0] lvl[NUM_SENSORS];
      logic [63:0] lo, peak, s, t, den, q, r, w;
      result_type res;
      lo = 0; peak = 0; s = 0; t = 0;
      for (int i = 0; i < NUM_SENSORS; i++)
         lvl[i] = (64'd1 << FRAC) / (64'd1 + rd[i]);
      lo = lvl[0];
      for (int i = 1; i < NUM_SENSORS; i++)
         if (lvl[i] < lo) lo = lvl[i];
      for (int i = 0; i < NUM_SENSORS; i++) begin
         w = (lvl[i] - lo) >> ((FRAC > 24) ? FRAC - 24 : 0);
         if (lvl[i] - lo > peak) peak = lvl[i] - lo;
         t += w * w;
         s += w * w * i;
      end
      res.lineness = peak[LINE_W-1:0];
      if (t == 0) begin
         res.position = '0;
         res.flat_frame = 1'b1;
      end else begin
         den = 7 * t;
         q = s / den;
         r = s % den;
         for (int k = 0; k < 16; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
               r -= den;
               q |= 1;
            end
         end
         if (q > 64'hFFFF) q = 64'hFFFF;
         res.position = q[15:0] ^ POS_BIAS;
         res.flat_frame = 1'b0;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // one frame, waits until accepted; valid stays up for the next frame
   task automatic send_frame(input reading_arr_type rd);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.reading_0 <= rd[0];
      req_bus.reading_1 <= rd[1];
      req_bus.reading_2 <= rd[2];
      req_bus.reading_3 <= rd[3];
      req_bus.reading_4 <= rd[4];
      req_bus.reading_5 <= rd[5];
      req_bus.reading_6 <= rd[6];
      req_bus.reading_7 <= rd[7];
      do @(posedge clock); while (!req_bus.ready);
      expected_q.push_back(estimate_position(rd));
      frames_sent++;
   endtask

   function automatic reading_arr_type all_same(input logic [15:0] v);
      reading_arr_type rd;
      for (int i = 0; i < NUM_SENSORS; i++) rd[i] = v;
      return rd;
   endfunction

   function automatic logic [15:0] rand_reading();
      case ($urandom_range(3))
         0: return 16'($urandom_range(15));
         1: return 16'($urandom_range(255));
         2: return 16'($urandom_range(65535, 65000));
         default: return 16'($urandom);
      endcase
   endfunction

   // line under a single sensor or a pair, dark background
   function automatic reading_arr_type line_frame();
      reading_arr_type rd;
      int c;
      c = $urandom_range(7);
      for (int i = 0; i < NUM_SENSORS; i++)
         rd[i] = 16'($urandom_range(65535, 2000));
      rd[c] = 16'($urandom_range(300));
      if (c < 7 && $urandom_range(1)) rd[c+1] = 16'($urandom_range(300));
      return rd;
   endfunction

   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else if (recv_hold)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("result count", results_seen + 1, frames_sent);
         end else begin
            want = expected_q.pop_front();
            if (rsp_bus.position !== want.position)
               report_mismatch("position", rsp_bus.position, want.position);
            if (rsp_bus.lineness !== want.lineness)
               report_mismatch("lineness", rsp_bus.lineness, want.lineness);
            if (rsp_bus.flat_frame !== want.flat_frame)
               report_mismatch("flat_frame", rsp_bus.flat_frame, want.flat_frame);
            if (want.flat_frame) flat_seen++;
         end
         results_seen++;
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic test_directed();
      reading_arr_type rd;
      send_frame(all_same(16'h0000));
      send_frame(all_same(16'hFFFF));
      send_frame(all_same(16'h1234));
      for (int c = 0; c < NUM_SENSORS; c++) begin
         rd = all_same(16'hFFFF);
         rd[c] = 16'h0000;
         send_frame(rd);
      end
      rd = all_same(16'h0000); rd[0] = 16'hFFFF; send_frame(rd);
      rd = all_same(16'h0000); rd[7] = 16'hFFFF; send_frame(rd);
      for (int i = 0; i < NUM_SENSORS; i++) rd[i] = 16'(i);
      send_frame(rd);
      for (int i = 0; i < NUM_SENSORS; i++) rd[i] = 16'(7 - i);
      send_frame(rd);
      for (int b = 0; b < 16; b += 4) begin
         for (int i = 0; i < NUM_SENSORS; i++) rd[i] = 16'(16'h5555 << (i % 2)) ^ 16'(1 << b);
         send_frame(rd);
      end
   endtask

   task automatic test_random(input int count);
      reading_arr_type rd;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(9))
            0: rd = all_same(rand_reading());
            1, 2, 3, 4, 5: rd = line_frame();
            default: for (int i = 0; i < NUM_SENSORS; i++) rd[i] = rand_reading();
         endcase
         send_frame(rd);
      end
   endtask

   // receiver holds off while the sender keeps pushing frames
   task automatic test_backpressure();
      fork
         begin
            recv_hold = 1'b1;
            repeat (3 * LATENCY) @(posedge clock);
            recv_hold = 1'b0;
         end
         test_random(150);
      join
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.reading_0 = '0; req_bus.reading_1 = '0;
      req_bus.reading_2 = '0; req_bus.reading_3 = '0;
      req_bus.reading_4 = '0; req_bus.reading_5 = '0;
      req_bus.reading_6 = '0; req_bus.reading_7 = '0;
      rsp_bus.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      send_idle_pct = 27; recv_idle_pct = 45;
      test_random(600);
      send_idle_pct = 45; recv_idle_pct = 27;
      test_random(600);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_backpressure();
      test_random(580);
      req_bus.valid <= 1'b0;
      while (expected_q.size() > 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("sent %0d frames, checked %0d results (%0d flat frames)",
               frames_sent, results_seen, flat_seen);
      $display("covered edge readings, single and paired lines, flat frames and stalls");
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
